// ===== src/bua_pkg.sv =====
// Shared definitions for the bitmap unit allocator: status codes, register
// indexes, parameter defaults and the controller/datapath interface structs.
// No dependencies.
package bua_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned MAP_WORDS_DEF = 32;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
  localparam logic [1:0] ST_IN_USE       = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_UNIT_BASE  = 2'd0;
  localparam logic [1:0] REG_UNIT_COUNT = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;   // write zero to the word at the pointer, step the pointer
    logic capture;  // take the requested unit from the input transfer
    logic a_setup;  // compute the word count and the scan start
    logic advance;  // step the scan pointer
    logic a_eval;   // examine the word that was read during the scan
    logic n_check;  // range check of a named request
    logic n_div;    // word index of a named request
    logic n_rem;    // bit index of a named request
    logic n_test;   // test the bit of a named request
    logic load;     // load the output register and commit the bitmap write
  } bua_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // clearing pass is at the last word
    logic size_zero;  // no units are managed
    logic found;      // the word under evaluation has a free unit
    logic rd_last;    // the word under evaluation is the last one to scan
    logic oor;        // the named request lies outside the managed range
    logic out_free;   // the output register can take a result
  } bua_stat_t;

endpackage

// ===== src/bua_ctrl.sv =====
// Controller state machine of the bitmap unit allocator.
// Depends on bua_pkg for the command and status structs.
module bua_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_any_unit,
  output logic               in_stall,
  input  bua_pkg::bua_stat_t stat,
  output bua_pkg::bua_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_A_SETUP = 4'd2;
  localparam logic [3:0] S_A_FILL  = 4'd3;
  localparam logic [3:0] S_A_SCAN  = 4'd4;
  localparam logic [3:0] S_N_CHECK = 4'd5;
  localparam logic [3:0] S_N_DIV   = 4'd6;
  localparam logic [3:0] S_N_REM   = 4'd7;
  localparam logic [3:0] S_N_TEST  = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_any_unit ? S_A_SETUP : S_N_CHECK;
        end
      end
      S_A_SETUP: begin
        cmd.a_setup = 1'b1;
        state_nxt   = stat.size_zero ? S_FINISH : S_A_FILL;
      end
      S_A_FILL: begin
        cmd.advance = 1'b1;
        state_nxt   = S_A_SCAN;
      end
      S_A_SCAN: begin
        cmd.a_eval  = 1'b1;
        cmd.advance = 1'b1;
        if (stat.found || stat.rd_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_N_CHECK: begin
        cmd.n_check = 1'b1;
        state_nxt   = stat.oor ? S_FINISH : S_N_DIV;
      end
      S_N_DIV: begin
        cmd.n_div = 1'b1;
        state_nxt = S_N_REM;
      end
      S_N_REM: begin
        cmd.n_rem = 1'b1;
        state_nxt = S_N_TEST;
      end
      S_N_TEST: begin
        cmd.n_test = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/bua_dp.sv =====
// Datapath of the bitmap unit allocator: configuration registers, bitmap
// memory, scan pointer, search hint and output register.
// Depends on bua_pkg for codes and the command and status structs.
module bua_dp #(
  parameter int unsigned WORD_BITS = bua_pkg::WORD_BITS_DEF,
  parameter int unsigned MAP_WORDS = bua_pkg::MAP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic [31:0]        in_requested_unit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_allocated_unit,
  input  bua_pkg::bua_cmd_t  cmd,
  output bua_pkg::bua_stat_t stat
);

  localparam int unsigned CAP    = WORD_BITS * MAP_WORDS;
  localparam int unsigned IW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW     = $clog2(WORD_BITS);
  localparam int unsigned WW     = 10;
  localparam int unsigned DIV_S  = 19;
  localparam int unsigned DIV_M  = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;

  logic [WORD_BITS-1:0] mem_r [0:MAP_WORDS-1];

  logic [31:0]          unit_base_r;
  logic [10:0]          unit_count_r;
  logic [IW-1:0]        ptr_r;
  logic [IW-1:0]        ptr_nxt;
  logic [IW-1:0]        hint_r;
  logic [IW-1:0]        start_r;
  logic [WW-1:0]        words_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 rd_last_r;
  logic [31:0]          req_r;
  logic [10:0]          off_r;
  logic [PW-1:0]        bit_r;
  logic [1:0]           st_r;
  logic [31:0]          res_r;
  logic                 add_base_r;
  logic                 wr_pend_r;
  logic [IW-1:0]        wr_addr_r;
  logic [WORD_BITS-1:0] wr_data_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_unit_r;

  logic [10:0]          size_c;
  logic [28:0]          words_prod;
  logic [WW-1:0]        words_c;
  logic [IW-1:0]        start_c;
  logic [WW:0]          ptr_inc;
  logic [IW-1:0]        ptr_step;
  logic [16:0]          first_bit;
  logic [16:0]          valid_bits;
  logic [WORD_BITS-1:0] eff_word;
  logic [WORD_BITS-1:0] zero_oh;
  logic [PW-1:0]        pos_c;
  logic                 full_c;
  logic [31:0]          off_c;
  logic                 oor_c;
  logic [27:0]          quo_prod;
  logic [16:0]          nbase;
  logic [16:0]          nbit;
  logic                 out_free;

  // Managed size, saturated to the bitmap capacity.
  assign size_c = (32'(unit_count_r) > CAP) ? 11'(CAP) : unit_count_r;

  // Words that hold managed units: ceil(size / WORD_BITS) by reciprocal.
  assign words_prod = 29'((12'(size_c) + 12'(WORD_BITS - 1)) * 29'(DIV_M));
  assign words_c    = WW'(words_prod[28:DIV_S]);
  assign start_c    = (WW'(hint_r) < words_c) ? hint_r : '0;

  // Scan order wraps to word zero past the last managed word.
  assign ptr_inc  = (WW + 1)'(ptr_r) + 1'b1;
  assign ptr_step = (ptr_inc >= {1'b0, words_r}) ? '0 : IW'(ptr_inc);

  // Word under evaluation, with bits at or past the size forced to used.
  assign first_bit  = 17'(rd_idx_r) * 17'(WORD_BITS);
  assign valid_bits = 17'(size_c) - first_bit;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      eff_word[j] = rd_data_r[j] | (17'(j) >= valid_bits);
    end
  end

  assign full_c  = &eff_word;
  assign zero_oh = ~eff_word & (eff_word + 1'b1);

  always_comb begin
    pos_c = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (zero_oh[j]) begin
        pos_c = pos_c | PW'(j);
      end
    end
  end

  // Named request: range check, then word index by reciprocal and bit index as the remainder.
  assign off_c    = req_r - unit_base_r;
  assign oor_c    = (req_r < unit_base_r) || (off_c >= 32'(size_c));
  assign quo_prod = 28'(28'(off_r) * 28'(DIV_M));
  assign nbase    = 17'(ptr_r) * 17'(WORD_BITS);
  assign nbit     = 17'(off_r) - nbase;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.clr_wr) begin
      ptr_nxt = stat.clr_last ? '0 : ptr_r + 1'b1;
    end else if (cmd.a_setup) begin
      ptr_nxt = start_c;
    end else if (cmd.advance) begin
      ptr_nxt = ptr_step;
    end else if (cmd.n_div) begin
      ptr_nxt = IW'(quo_prod[27:DIV_S]);
    end
  end

  assign stat.clr_last  = (ptr_r == IW'(MAP_WORDS - 1));
  assign stat.size_zero = (size_c == '0);
  assign stat.found     = !full_c;
  assign stat.rd_last   = rd_last_r;
  assign stat.oor       = oor_c;
  assign stat.out_free  = out_free;

  // Bitmap memory: one write port, one registered read at the pointer.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem_r[ptr_r] <= '0;
    end else if (cmd.load && wr_pend_r) begin
      mem_r[wr_addr_r] <= wr_data_r;
    end
    rd_data_r <= mem_r[ptr_r];
    rd_idx_r  <= ptr_r;
    rd_last_r <= (ptr_step == start_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_base_r  <= '0;
      unit_count_r <= 11'd1024;
      ptr_r        <= '0;
      hint_r       <= '0;
      wr_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bua_pkg::REG_UNIT_BASE:  unit_base_r  <= cfg_wdata;
          bua_pkg::REG_UNIT_COUNT: unit_count_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (cmd.a_setup || cmd.n_check) begin
        wr_pend_r <= 1'b0;
      end else if (cmd.a_eval && !full_c) begin
        wr_pend_r <= 1'b1;
        hint_r    <= rd_idx_r;
      end else if (cmd.n_test && !rd_data_r[bit_r]) begin
        wr_pend_r <= 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_requested_unit;
    end
    if (cmd.a_setup) begin
      words_r    <= words_c;
      start_r    <= start_c;
      st_r       <= bua_pkg::ST_EXHAUSTED;
      res_r      <= '0;
      add_base_r <= 1'b0;
    end
    if (cmd.a_eval && !full_c) begin
      st_r       <= bua_pkg::ST_OK;
      res_r      <= 32'(first_bit + 17'(pos_c));
      add_base_r <= 1'b1;
      wr_addr_r  <= rd_idx_r;
      wr_data_r  <= rd_data_r | zero_oh;
    end
    if (cmd.n_check) begin
      off_r      <= off_c[10:0];
      st_r       <= bua_pkg::ST_OUT_OF_RANGE;
      res_r      <= '0;
      add_base_r <= 1'b0;
    end
    if (cmd.n_rem) begin
      bit_r <= nbit[PW-1:0];
    end
    if (cmd.n_test) begin
      if (rd_data_r[bit_r]) begin
        st_r <= bua_pkg::ST_IN_USE;
      end else begin
        st_r      <= bua_pkg::ST_OK;
        res_r     <= req_r;
        wr_addr_r <= rd_idx_r;
        wr_data_r <= rd_data_r | (WORD_BITS'(1) << bit_r);
      end
    end
    if (cmd.load) begin
      out_status_r <= st_r;
      out_unit_r   <= add_base_r ? (unit_base_r + res_r) : res_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_allocated_unit = out_unit_r;

endmodule

// ===== src/bitmap_unit_allocator.sv =====
// Top level of the bitmap unit allocator: controller plus datapath.
// Depends on bua_pkg, bua_ctrl and bua_dp.
//
// Usage: each request arrives on the in_ channel (in_valid / in_stall) and
// asks either for any free unit (in_any_unit high) or for the unit named by
// in_requested_unit. Every request yields exactly one result on the out_
// channel: a status and the granted unit, zero unless the status is ok. The
// cfg_ port writes unit_base (index 0) and unit_count (index 1) while no
// request is in flight; the user ensures this, the block does not enforce it.
// A named request passes the range check, word index, bit index and bit
// test before its result is loaded, or goes from the range check straight
// to loading if it lies outside the managed range. An any-unit request
// reads one bitmap word per cycle from the memory's single read port,
// starting at the hint word, and stops at the first word with a free unit
// or after the last word that holds managed units; with no units managed
// it skips the scan. The in_stall output stays high from a transfer until
// its result is in the output register, when the next transfer can come.
// After reset the bitmap is cleared one word per cycle with in_stall high,
// and the hint and both registers reset. A stalled result waits in the
// output register; one more request may transfer and its result waits inside.
module bitmap_unit_allocator #(
  parameter int unsigned WORD_BITS = bua_pkg::WORD_BITS_DEF,
  parameter int unsigned MAP_WORDS = bua_pkg::MAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_any_unit,
  input  logic [31:0] in_requested_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_allocated_unit
);

  bua_pkg::bua_cmd_t  cmd;
  bua_pkg::bua_stat_t stat;

  // The controller sequences each request; the datapath holds all storage.
  bua_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_any_unit (in_any_unit),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  bua_dp #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_requested_unit  (in_requested_unit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_allocated_unit (out_allocated_unit),
    .cmd                (cmd),
    .stat               (stat)
  );

`ifndef ASSERT_OFF
  // A transfer on the input is followed by a busy cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer not followed by stall");

  // A failed request never reports a unit.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bua_pkg::ST_OK || out_allocated_unit == 32'd0))
    else $error("non-ok result carries a unit");

  // No request is taken while the bitmap is being cleared.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> in_stall)
    else $error("input accepted during clearing pass");

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled output");
`endif

endmodule
